FILE: rtl/core/cpa_pkg.sv
`default_nettype none

package cpa_pkg;

  localparam int CORE_TOTAL = 4;
  localparam int MAX_PARTS = 15;

  typedef logic [3:0] part_t;
  typedef logic [CORE_TOTAL-1:0][3:0] owner_table_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_V2P   = 3'd2,
    KIND_P2V   = 3'd3,
    KIND_VMASK = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    part_t       part_id;
    logic [4:0]  core_count;
    logic [3:0]  core_index;
    logic [15:0] core_mask;
  } cpa_req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  core_result;
    logic [15:0] mask_result;
  } cpa_result_t;

  typedef struct packed {
    logic [CORE_TOTAL-1:0] wr;
    part_t                 val;
  } cpa_update_t;

endpackage

`default_nettype wire

FILE: rtl/core/core_partition_allocator.sv
`default_nettype none

// Channel  Handshake          Fields
// ------   -----------------  ----------------------------------------------
// request  start / busy       kind, part_id, core_count, core_index, core_mask
// result   done (strobe)      status, core_result, mask_result
//
// One item is accepted in every cycle; busy stays low.
// Each result leaves the request register, then the output registers, and is on the
// ports with done high, in order. The owner table is read and written in the cycle
// after acceptance, so the next item already sees the update.
// Reset frees every core and drops work in flight.
// The receiver cannot stall; a result is valid for the single cycle of done.

module core_partition_allocator
  import cpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [3:0]  part_id,
  input  wire logic [4:0]  core_count,
  input  wire logic [3:0]  core_index,
  input  wire logic [15:0] core_mask,
  output logic             done,
  output logic [1:0]       status,
  output logic [3:0]       core_result,
  output logic [15:0]      mask_result
);

  owner_table_t owner;
  cpa_req_t     req;
  logic         req_valid;
  cpa_result_t  res;
  cpa_update_t  upd;

  assign busy = 1'b0;

  cpa_engine u_engine (
    .owner (owner),
    .req   (req),
    .res   (res),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done      <= 1'b0;
      owner     <= '0;
    end else begin
      req_valid <= start && !busy;
      done      <= req_valid;
      if (req_valid) begin
        for (int c = 0; c < CORE_TOTAL; c++) begin
          if (upd.wr[c]) begin
            owner[c] <= upd.val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.kind       <= kind;
      req.part_id    <= part_id;
      req.core_count <= core_count;
      req.core_index <= core_index;
      req.core_mask  <= core_mask;
    end
    status      <= res.status;
    core_result <= res.core_result;
    mask_result <= res.mask_result;
  end

endmodule

`default_nettype wire

FILE: rtl/core/cpa_engine.sv
`default_nettype none

module cpa_engine
  import cpa_pkg::*;
(
  input  owner_table_t owner,
  input  cpa_req_t     req,
  output cpa_result_t  res,
  output cpa_update_t  upd
);

  logic [CORE_TOTAL-1:0]      owned;
  logic [CORE_TOTAL-1:0]      free;
  logic [CORE_TOTAL-1:0][3:0] pre_own;
  logic [CORE_TOTAL-1:0]      grant;
  logic [CORE_TOTAL-1:0]      pmask;
  logic [4:0]                 cnt_own;
  logic [4:0]                 cnt_free;
  logic [15:0]                vok;
  logic                       part_ok;
  logic                       count_ok;
  logic                       v2p_hit;
  logic [3:0]                 v2p_core;
  logic                       p2v_hit;
  logic [3:0]                 p2v_index;
  logic                       vmask_bad;

  always_comb begin
    cnt_own   = '0;
    cnt_free  = '0;
    owned     = '0;
    free      = '0;
    pre_own   = '0;
    grant     = '0;
    pmask     = '0;
    v2p_hit   = 1'b0;
    v2p_core  = '0;
    p2v_hit   = 1'b0;
    p2v_index = '0;
    for (int c = 0; c < CORE_TOTAL; c++) begin
      owned[c]   = (owner[c] == req.part_id);
      free[c]    = (owner[c] == '0);
      pre_own[c] = cnt_own[3:0];
      grant[c]   = free[c] && (cnt_free < req.core_count);
      if (owned[c]) begin
        cnt_own = cnt_own + 5'd1;
      end
      if (free[c]) begin
        cnt_free = cnt_free + 5'd1;
      end
    end
    for (int c = 0; c < CORE_TOTAL; c++) begin
      if (owned[c] && (pre_own[c] == req.core_index)) begin
        v2p_hit  = 1'b1;
        v2p_core = 4'(c);
      end
      if ((4'(c) == req.core_index) && owned[c]) begin
        p2v_hit   = 1'b1;
        p2v_index = pre_own[c];
      end
      pmask[c] = owned[c] && req.core_mask[pre_own[c]];
    end
    for (int v = 0; v < 16; v++) begin
      vok[v] = (5'(v) < cnt_own);
    end
    vmask_bad = |(req.core_mask & ~vok);
    part_ok   = (req.part_id != '0) && (req.part_id <= 4'(MAX_PARTS));
    count_ok  = (req.core_count != '0) && (req.core_count <= 5'(CORE_TOTAL));

    res.status      = ST_INVALID;
    res.core_result = '0;
    res.mask_result = '0;
    upd.wr          = '0;
    upd.val         = req.part_id;
    if (part_ok) begin
      unique case (req.kind)
        KIND_START: begin
          if (count_ok && (owned == '0)) begin
            if (cnt_free < req.core_count) begin
              res.status = ST_BUSY;
            end else begin
              res.status      = ST_OK;
              res.mask_result = 16'(grant);
              upd.wr          = grant;
            end
          end
        end
        KIND_STOP: begin
          res.status = ST_OK;
          upd.wr     = owned;
          upd.val    = '0;
        end
        KIND_V2P: begin
          if (v2p_hit) begin
            res.status      = ST_OK;
            res.core_result = v2p_core;
          end
        end
        KIND_P2V: begin
          if (p2v_hit) begin
            res.status      = ST_OK;
            res.core_result = p2v_index;
          end
        end
        KIND_VMASK: begin
          if (!vmask_bad) begin
            res.status      = ST_OK;
            res.mask_result = 16'(pmask);
          end
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cpa_checker.sv
`default_nettype none

module cpa_checker
  import cpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  kind,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [3:0]  core_result,
  input wire logic [15:0] mask_result
);

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("accepted item gave no result two cycles later");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (status == ST_BUSY) || (status == ST_INVALID))
    else $error("undefined status code");

  a_error_clear : assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (core_result == '0) && (mask_result == '0))
    else $error("failed item carries nonzero result data");

  a_start_grant : assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK) && ($past(kind, 2) == KIND_START) |-> (mask_result != '0))
    else $error("successful start granted no cores");

endmodule

bind core_partition_allocator cpa_checker u_cpa_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .done        (done),
  .status      (status),
  .core_result (core_result),
  .mask_result (mask_result)
);

`default_nettype wire

FILE: dv/core_partition_allocator_tb.sv
`timescale 1ns / 100ps

module core_partition_allocator_tb
  import cpa_pkg::*;
;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_GAP = 40;
  localparam int RANDOM_ITEMS = 900;
  localparam int REPORT_LIMIT = 10;

  class partition_tracker;
    part_t       owners[CORE_TOTAL];
    cpa_result_t awaited[$];
    int          errors;

    function new();
      foreach (owners[c]) owners[c] = '0;
      errors = 0;
    endfunction

    function int owned_count(part_t p);
      int n;
      n = 0;
      foreach (owners[c]) if (owners[c] == p) n++;
      return n;
    endfunction

    function bit find_phys(part_t p, int k, output int phys);
      int seen;
      seen = 0;
      phys = 0;
      for (int c = 0; c < CORE_TOTAL; c++) begin
        if (owners[c] == p) begin
          if (seen == k) begin
            phys = c;
            return 1'b1;
          end
          seen++;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [2:0] k, part_t p, logic [4:0] cnt,
                               logic [3:0] idx, logic [15:0] vm);
      cpa_result_t r;
      int          free_cnt;
      int          phys;
      int          below;
      logic [15:0] grant;
      logic [15:0] pm;
      bit          bad;
      r.status = ST_INVALID;
      r.core_result = '0;
      r.mask_result = '0;
      if (p != 0 && p <= MAX_PARTS) begin
        case (kind_t'(k))
          KIND_START: begin
            if (cnt != 0 && cnt <= CORE_TOTAL && owned_count(p) == 0) begin
              free_cnt = 0;
              grant = '0;
              for (int c = 0; c < CORE_TOTAL; c++) begin
                if (owners[c] == 0) begin
                  if (free_cnt < cnt) grant[c] = 1'b1;
                  free_cnt++;
                end
              end
              if (free_cnt < cnt) begin
                r.status = ST_BUSY;
              end else begin
                for (int c = 0; c < CORE_TOTAL; c++) if (grant[c]) owners[c] = p;
                r.status = ST_OK;
                r.mask_result = grant;
              end
            end
          end
          KIND_STOP: begin
            foreach (owners[c]) if (owners[c] == p) owners[c] = '0;
            r.status = ST_OK;
          end
          KIND_V2P: begin
            if (find_phys(p, int'(idx), phys)) begin
              r.status = ST_OK;
              r.core_result = phys[3:0];
            end
          end
          KIND_P2V: begin
            if (idx < CORE_TOTAL && owners[idx] == p) begin
              below = 0;
              for (int c = 0; c < idx; c++) if (owners[c] == p) below++;
              r.status = ST_OK;
              r.core_result = below[3:0];
            end
          end
          KIND_VMASK: begin
            pm = '0;
            bad = 1'b0;
            for (int c = 0; c < 16; c++) begin
              if (vm[c]) begin
                if (find_phys(p, c, phys)) pm[phys] = 1'b1;
                else bad = 1'b1;
              end
            end
            if (!bad) begin
              r.status = ST_OK;
              r.mask_result = pm;
            end
          end
          default: ;
        endcase
      end
      awaited.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [3:0] cr, logic [15:0] mr);
      cpa_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no item pending: status %0d core %0d mask %h",
                   $time, st, cr, mr);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || cr !== e.core_result || mr !== e.mask_result) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: expected status %0d core %0d mask %h, got status %0d core %0d mask %h",
                   $time, e.status, e.core_result, e.mask_result, st, cr, mr);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [3:0]  part_id;
  logic [4:0]  core_count;
  logic [3:0]  core_index;
  logic [15:0] core_mask;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  core_result;
  logic [15:0] mask_result;

  partition_tracker tracker = new();
  int               gap_pct;
  int               quiet_cycles;

  core_partition_allocator uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .part_id(part_id),
    .core_count(core_count),
    .core_index(core_index),
    .core_mask(core_mask),
    .done(done),
    .status(status),
    .core_result(core_result),
    .mask_result(mask_result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start === 1'b1 && busy === 1'b0)
        tracker.note_request(kind, part_id, core_count, core_index, core_mask);
      if (done === 1'b1)
        tracker.check_response(status, core_result, mask_result);
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [3:0] p, input logic [4:0] c,
                           input logic [3:0] x, input logic [15:0] m);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      kind <= $urandom;
      part_id <= $urandom;
      core_count <= $urandom;
      core_index <= $urandom;
      core_mask <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    part_id <= p;
    core_count <= c;
    core_index <= x;
    core_mask <= m;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin
    int          pick;
    logic [2:0]  k;
    logic [3:0]  p;
    logic [4:0]  c;
    logic [3:0]  x;
    logic [15:0] m;
    int          phase_pct[4];

    phase_pct = '{0, 79, 0, 17};
    rst = 1'b1;
    start = 1'b0;
    kind = '0;
    part_id = '0;
    core_count = '0;
    core_index = '0;
    core_mask = '0;
    gap_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(KIND_START, 4'd1, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd1, 5'd5, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd1, 5'd31, 4'd15, 16'hFFFF);
    send_item(KIND_START, 4'd0, 5'd1, 4'd0, 16'h0000);
    for (int u = int'(KIND_VMASK) + 1; u < 8; u++)
      send_item(u[2:0], 4'd1, 5'd1, 4'd0, 16'h0001);
    send_item(KIND_START, 4'd1, 5'd1, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd1, 5'd1, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd2, 5'd2, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd3, 5'd2, 4'd0, 16'h0000);
    send_item(KIND_V2P, 4'd2, 5'd0, 4'd1, 16'h0000);
    send_item(KIND_V2P, 4'd2, 5'd0, 4'd2, 16'h0000);
    send_item(KIND_V2P, 4'd2, 5'd0, 4'd15, 16'h0000);
    send_item(KIND_P2V, 4'd2, 5'd0, 4'd2, 16'h0000);
    send_item(KIND_P2V, 4'd2, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_P2V, 4'd2, 5'd0, 4'd15, 16'h0000);
    send_item(KIND_VMASK, 4'd2, 5'd0, 4'd0, 16'h0003);
    send_item(KIND_VMASK, 4'd2, 5'd0, 4'd0, 16'hFFFF);
    send_item(KIND_VMASK, 4'd2, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_STOP, 4'd1, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_STOP, 4'd9, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd15, 5'd4, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd15, 5'd2, 4'd0, 16'h0000);
    send_item(KIND_STOP, 4'd2, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_STOP, 4'd15, 5'd0, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd4, 5'd16, 4'd0, 16'h0000);
    send_item(KIND_START, 4'd4, 5'd4, 4'd0, 16'h0000);
    send_item(KIND_STOP, 4'd4, 5'd0, 4'd0, 16'h0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gap_pct = phase_pct[i * 4 / RANDOM_ITEMS];
      k = ($urandom_range(99) < 5) ? 3'($urandom_range(int'(KIND_VMASK) + 1, 7))
                                   : 3'($urandom_range(0, int'(KIND_VMASK)));
      p = ($urandom_range(99) < 8) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 5));
      c = ($urandom_range(99) < 8) ? 5'($urandom_range(0, 31))
                                   : 5'($urandom_range(1, CORE_TOTAL));
      x = ($urandom_range(99) < 10) ? 4'($urandom_range(0, 15))
                                    : 4'($urandom_range(0, CORE_TOTAL - 1));
      pick = $urandom_range(99);
      if (pick < 10) m = 16'($urandom);
      else if (pick < 25) m = 16'($urandom_range(0, 15));
      else m = 16'($urandom) & 16'((1 << tracker.owned_count(p)) - 1);
      send_item(k, p, c, x, m);
    end

    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cpa_pkg.sv
rtl/core/cpa_engine.sv
rtl/core/core_partition_allocator.sv
rtl/core/cpa_checker.sv
dv/core_partition_allocator_tb.sv
